// File: src/pq_pkg.sv
// Shared types and constants for the positional insert queue.
package pq_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int CNT_W       = 5;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int DEPTH_DFLT  = 16;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 104;

  localparam logic [DATA_W-1:0] NONE_VALUE = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_DELETE = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_POP = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: src/pq_cell.sv
// One storage cell of the queue: holds, loads, or takes a neighbor's entry.
module pq_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                      clk_i,
  input  pq_pkg::cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic [pq_pkg::DATA_W-1:0] left_i,
  input  logic [pq_pkg::DATA_W-1:0] right_i,
  output logic [pq_pkg::DATA_W-1:0] data_o
);
  import pq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      OP_INS: begin
        if (MY_IDX > idx_i) begin
          data_d = left_i;
        end else if (MY_IDX == idx_i) begin
          data_d = ctl_i.value;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= idx_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: src/positional_insert_queue.sv
// Top level of the positional insert queue built as a chain of shift cells.
//
// Slave stream carries one operation per transaction: tuser holds the
// function (push, pop, insert at position, delete at position), tdata holds
// the value and the 1-based position. Master stream returns one result per
// operation: popped value, front and rear values, count, empty flag, status.
//
// Every cell decides locally to hold, load the new value, or take its left
// or right neighbor, so an operation updates the whole row at once. The
// result is registered and valid in the cycle after the operation is accepted.
// Throughput is one operation per cycle; a new operation is taken in the same
// cycle the pending result is taken, set by the single result register.
//
// When the receiver stalls, the result holds and no new operation is taken.
// Reset empties the queue and drops any pending result; cell contents are
// not cleared, entries beyond the count are never shown.
module positional_insert_queue #(
  parameter int DEPTH = pq_pkg::DEPTH_DFLT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] value, [36:32] position, [39:37] zero
  input  logic [pq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] func
  input  logic [pq_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] popped, [63:32] front_value, [95:64] rear_value,
  // [100:96] count, [101] is_empty, [103:102] status
  output logic [pq_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  logic              accept;
  func_e             func;
  logic [DATA_W-1:0] in_value;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  occ_c;
  logic [CMP_W-1:0]  pos_m1;

  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] popped_q, popped_d;
  stat_e             status_q, status_d;

  cell_ctl_t         ctl;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] cell_data [DEPTH];

  logic [OCC_W-1:0]  occ_m1;
  logic              empty;
  logic [DATA_W-1:0] front_value;
  logic [DATA_W-1:0] rear_value;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = func_e'(s_axis_tuser);
  assign in_value      = s_axis_tdata[DATA_W-1:0];
  assign pos_c         = CMP_W'(s_axis_tdata[DATA_W+POS_W-1:DATA_W]);
  assign occ_c         = CMP_W'(occ_q);
  assign pos_m1        = pos_c - CMP_W'(1);

  always_comb begin
    ctl.op    = OP_HOLD;
    ctl.value = in_value;
    idx       = '0;
    occ_d     = occ_q;
    popped_d  = NONE_VALUE;
    status_d  = ST_OK;
    case (func)
      FN_PUSH: begin
        if (occ_q == FULL_OCC) begin
          status_d = ST_FULL;
        end else begin
          ctl.op = OP_INS;
          idx    = occ_c[IDX_W-1:0];
          occ_d  = occ_q + OCC_W'(1);
        end
      end
      FN_POP: begin
        if (occ_q == '0) begin
          status_d = ST_EMPTY_POP;
        end else begin
          ctl.op   = OP_DEL;
          popped_d = cell_data[0];
          occ_d    = occ_q - OCC_W'(1);
        end
      end
      FN_INSERT: begin
        if (occ_q == FULL_OCC) begin
          status_d = ST_FULL;
        end else if (pos_c == '0 || pos_c > occ_c + CMP_W'(1)) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.op = OP_INS;
          idx    = pos_m1[IDX_W-1:0];
          occ_d  = occ_q + OCC_W'(1);
        end
      end
      FN_DELETE: begin
        if (pos_c == '0 || pos_c > occ_c) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.op = OP_DEL;
          idx    = pos_m1[IDX_W-1:0];
          occ_d  = occ_q - OCC_W'(1);
        end
      end
      default: status_d = ST_OK;
    endcase
    if (!accept) begin
      ctl.op = OP_HOLD;
      occ_d  = occ_q;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (k == 0) begin : g_first
      assign left = in_value;
    end else begin : g_mid_l
      assign left = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = cell_data[k];
    end else begin : g_mid_r
      assign right = cell_data[k+1];
    end
    pq_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (idx),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  // queue state only moves on an accepted transaction, so it stays put while a result waits
  assign occ_m1      = occ_q - OCC_W'(1);
  assign empty       = (occ_q == '0);
  assign front_value = empty ? NONE_VALUE : cell_data[0];
  assign rear_value  = empty ? NONE_VALUE : cell_data[occ_m1[IDX_W-1:0]];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {status_q, empty, CNT_W'(occ_q), rear_value, front_value, popped_q};

endmodule

// File: src/pq_checker.sv
// Port-level checks for the positional insert queue, bound to the top level.
module pq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [pq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [pq_pkg::FUNC_W-1:0]    s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pq_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pq_pkg::*;

  logic [DATA_W-1:0] popped;
  logic [DATA_W-1:0] front_value;
  logic [DATA_W-1:0] rear_value;
  logic [CNT_W-1:0]  count;
  logic              is_empty;
  logic [STAT_W-1:0] status;

  assign popped      = m_axis_tdata[31:0];
  assign front_value = m_axis_tdata[63:32];
  assign rear_value  = m_axis_tdata[95:64];
  assign count       = m_axis_tdata[100:96];
  assign is_empty    = m_axis_tdata[101];
  assign status      = m_axis_tdata[103:102];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_EMPTY_POP |-> is_empty && popped == NONE_VALUE)
    else $error("empty pop reported with entries or a value");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && is_empty |-> front_value == NONE_VALUE && rear_value == NONE_VALUE)
    else $error("empty queue shows front or rear value");

endmodule

bind positional_insert_queue pq_checker u_pq_checker (.*);
